FILE: hw/rtl/ghi_pkg.sv
// Shared types and constants for the gyro heading integrator.
// No dependencies; every other file of the block imports this package.
package ghi_pkg;

  localparam int HEAD_W  = 33;
  localparam int RATE_W  = 16;
  localparam int DT_W    = 16;
  localparam int CFG_W   = 32;
  localparam int DB_W    = 25;
  localparam int CLEN_W  = 11;
  localparam int MAG_W   = 32;
  localparam int PROD_W  = 64;
  localparam int FRAC_W  = 29;
  localparam int Q_W     = 36;
  localparam int REG_IDX_W = 2;
  localparam int RED_STEPS = 3;
  localparam int STEP_W  = 2;

  localparam logic [HEAD_W-1:0] FULL_TURN = 33'd6039797760;

  localparam logic [CFG_W-1:0]  RATE_SCALE_RST = 32'd76677120;
  localparam logic [DB_W-1:0]   DEADBAND_RST   = 25'd167772;
  localparam logic [CLEN_W-1:0] CALIB_RST      = 11'd300;

  localparam logic [REG_IDX_W-1:0] REG_RATE_SCALE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEADBAND      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CALIB_SAMPLES = 2'd2;

  typedef enum logic [1:0] {
    OP_RUN     = 2'd0,
    OP_CALIB   = 2'd1,
    OP_SET     = 2'd2,
    OP_RESTART = 2'd3
  } ghi_op_t;

  typedef struct packed {
    ghi_op_t                  op;
    logic signed [RATE_W-1:0] rate_sample;
    logic [DT_W-1:0]          time_step;
    logic [HEAD_W-1:0]        new_heading;
  } ghi_in_t;

  typedef struct packed {
    logic [HEAD_W-1:0]        heading;
    logic signed [RATE_W-1:0] corrected_rate;
    logic signed [RATE_W-1:0] bias;
    logic                     calibrated;
  } ghi_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ghi_unit_stat_t;

endpackage

FILE: hw/rtl/ghi_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ghi_pkg for widths and the unit status type.
module ghi_smul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ghi_pkg::MAG_W-1:0]  mcand,
  input  logic [ghi_pkg::CFG_W-1:0]  mplier,
  output logic [ghi_pkg::PROD_W-1:0] prod,
  output ghi_pkg::ghi_unit_stat_t    stat
);
  import ghi_pkg::*;

  localparam int CNT_W = $clog2(CFG_W);

  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] acc_nxt;
  logic [MAG_W-1:0]  a_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MAG_W:0]    part;

  assign part    = {1'b0, acc_r[PROD_W-1:CFG_W]} + {1'b0, a_r};
  assign acc_nxt = acc_r[0] ? {part, acc_r[CFG_W-1:1]} : {1'b0, acc_r[PROD_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= mcand;
      acc_r <= {{MAG_W{1'b0}}, mplier};
      cnt_r <= CNT_W'(CFG_W - 1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign prod = acc_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule

FILE: hw/rtl/ghi_sdiv.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ghi_pkg for the unit status type.
module ghi_sdiv #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUM_W-1:0]        num,
  input  logic [DEN_W-1:0]        den,
  output logic [NUM_W-1:0]        quo,
  output ghi_pkg::ghi_unit_stat_t stat
);
  import ghi_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W+1:0] trial;
  logic             fits;

  assign trial = {1'b0, rem_r, num_r[NUM_W-1]} - {2'b0, den_r};
  assign fits  = !trial[DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      cnt_r <= CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      rem_r <= fits ? trial[DEN_W-1:0] : {rem_r[DEN_W-2:0], num_r[NUM_W-1]};
      num_r <= {num_r[NUM_W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quo  = num_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule

FILE: hw/rtl/gyro_heading_integrator.sv
// Top level of the gyro heading integrator: sequencer, state and I/O registers.
// Depends on ghi_pkg, ghi_smul and ghi_sdiv.
//
//   channel | signals                         | payload
//   --------+---------------------------------+-----------
//   in      | in_valid, in_stall, in_data     | ghi_in_t
//   out     | out_valid, out_stall, out_data  | ghi_out_t
//   cfg     | cfg_we, cfg_index, cfg_wdata    | 32-bit word
//
// One request at a time. A run sample passes through a serial multiply and three modulo
// reduction steps before its result is registered. A closing calibration sample waits
// on the serial divider; other ops go from decode straight to the output stage.
// Reset is synchronous; no clearing pass. A finished result waits in the output
// register while the next request is accepted; a stalled output holds the sequencer.
module gyro_heading_integrator #(
  parameter int MAX_CALIB = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ghi_pkg::ghi_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ghi_pkg::ghi_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [ghi_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [ghi_pkg::CFG_W-1:0]    cfg_wdata
);
  import ghi_pkg::*;

  localparam int CNT_RAW = $clog2(MAX_CALIB + 1);
  localparam int CNT_W   = CNT_RAW < 2 ? 2 : CNT_RAW;
  localparam int SUM_W   = RATE_W + CNT_W;
  localparam int LEN_W   = CNT_W > CLEN_W ? CNT_W : CLEN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MAG, S_MUL, S_RND, S_RED, S_ACC, S_DIV, S_FIN
  } state_t;

  state_t                   state_r;
  ghi_in_t                  item_r;
  logic signed [RATE_W-1:0] corr_r;
  logic                     neg_r;
  logic [MAG_W-1:0]         mag_r;
  logic [Q_W-1:0]           r_r;
  logic [STEP_W-1:0]        step_r;
  logic [HEAD_W-1:0]        heading_r;
  logic signed [RATE_W-1:0] prev_r;
  logic signed [RATE_W-1:0] bias_r;
  logic signed [SUM_W-1:0]  csum_r;
  logic [CNT_W-1:0]         ccount_r;
  logic                     cdone_r;
  logic                     sum_neg_r;
  logic [SUM_W-1:0]         div_num_r;
  logic [CNT_W-1:0]         div_den_r;
  logic                     mul_start_r;
  logic                     div_start_r;
  logic                     out_valid_r;
  ghi_out_t                 out_data_r;

  logic [CFG_W-1:0]  rate_scale_r;
  logic [DB_W-1:0]   deadband_r;
  logic [CLEN_W-1:0] calib_r;

  logic [PROD_W-1:0] prod;
  ghi_unit_stat_t    mul_stat;
  logic [SUM_W-1:0]  quo;
  ghi_unit_stat_t    div_stat;

  logic signed [RATE_W:0]   diff;
  logic signed [RATE_W-1:0] corr_sat;
  logic signed [RATE_W:0]   tsum;
  logic [RATE_W:0]          tabs;
  logic [MAG_W-1:0]         mag_full;
  logic [Q_W-1:0]           q_rnd;
  logic                     below_db;
  logic [Q_W-1:0]           turn_sh;
  logic [HEAD_W:0]          up;
  logic [HEAD_W:0]          up_w;
  logic [HEAD_W:0]          dn;
  logic [HEAD_W:0]          dn_w;
  logic [HEAD_W-1:0]        loaded_w;
  logic signed [SUM_W-1:0]  csum_nxt;
  logic [SUM_W-1:0]         csum_abs;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [LEN_W-1:0]         cal_ext;
  logic [LEN_W-1:0]         max_ext;
  logic [LEN_W-1:0]         len;
  logic signed [SUM_W:0]    qs;
  logic [SUM_W-RATE_W+1:0]  qs_hi;
  logic signed [RATE_W-1:0] bias_sat;
  logic                     out_free;

  ghi_smul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start_r),
    .mcand  (mag_r),
    .mplier (rate_scale_r),
    .prod   (prod),
    .stat   (mul_stat)
  );

  ghi_sdiv #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .quo   (quo),
    .stat  (div_stat)
  );

  always_comb begin
    diff = {item_r.rate_sample[RATE_W-1], item_r.rate_sample} - {bias_r[RATE_W-1], bias_r};
    if (diff[RATE_W] != diff[RATE_W-1]) begin
      corr_sat = diff[RATE_W] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
    end else begin
      corr_sat = diff[RATE_W-1:0];
    end

    tsum     = {corr_r[RATE_W-1], corr_r} + {prev_r[RATE_W-1], prev_r};
    tabs     = tsum[RATE_W] ? 17'(-tsum) : 17'(tsum);
    mag_full = MAG_W'(tabs) * MAG_W'(item_r.time_step);

    q_rnd    = {1'b0, prod[PROD_W-1:FRAC_W]} + Q_W'(neg_r & (|prod[FRAC_W-1:0]));
    below_db = q_rnd < Q_W'(deadband_r);
    turn_sh  = Q_W'(FULL_TURN) << step_r;

    up   = {1'b0, heading_r} + {1'b0, r_r[HEAD_W-1:0]};
    up_w = (up >= {1'b0, FULL_TURN}) ? up - {1'b0, FULL_TURN} : up;
    dn   = {1'b0, heading_r} - {1'b0, r_r[HEAD_W-1:0]};
    dn_w = dn[HEAD_W] ? dn + {1'b0, FULL_TURN} : dn;

    loaded_w = (item_r.new_heading >= FULL_TURN) ? item_r.new_heading - FULL_TURN
                                                 : item_r.new_heading;

    csum_nxt = csum_r + {{(SUM_W-RATE_W){item_r.rate_sample[RATE_W-1]}}, item_r.rate_sample};
    csum_abs = csum_nxt[SUM_W-1] ? SUM_W'(-csum_nxt) : SUM_W'(csum_nxt);
    cnt_nxt  = ccount_r + 1'b1;
    cal_ext  = LEN_W'(calib_r);
    max_ext  = LEN_W'(MAX_CALIB);
    if (cal_ext == '0) begin
      len = LEN_W'(1);
    end else if (cal_ext > max_ext) begin
      len = max_ext;
    end else begin
      len = cal_ext;
    end

    qs    = sum_neg_r ? -{1'b0, quo} : {1'b0, quo};
    qs_hi = qs[SUM_W:RATE_W-1];
    if ((&qs_hi) || !(|qs_hi)) begin
      bias_sat = qs[RATE_W-1:0];
    end else begin
      bias_sat = qs[SUM_W] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
    end

    out_free = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_scale_r <= RATE_SCALE_RST;
      deadband_r   <= DEADBAND_RST;
      calib_r      <= CALIB_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE_SCALE:    rate_scale_r <= cfg_wdata;
        REG_DEADBAND:      deadband_r   <= cfg_wdata[DB_W-1:0];
        REG_CALIB_SAMPLES: calib_r      <= cfg_wdata[CLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      heading_r   <= '0;
      prev_r      <= '0;
      bias_r      <= '0;
      csum_r      <= '0;
      ccount_r    <= '0;
      cdone_r     <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            corr_r  <= '0;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          unique case (item_r.op)
            OP_RUN: begin
              corr_r  <= corr_sat;
              state_r <= S_MAG;
            end
            OP_CALIB: begin
              if (cdone_r) begin
                state_r <= S_FIN;
              end else begin
                csum_r   <= csum_nxt;
                ccount_r <= cnt_nxt;
                if (LEN_W'(cnt_nxt) >= len) begin
                  div_start_r <= 1'b1;
                  div_num_r   <= csum_abs;
                  div_den_r   <= cnt_nxt;
                  sum_neg_r   <= csum_nxt[SUM_W-1];
                  state_r     <= S_DIV;
                end else begin
                  state_r <= S_FIN;
                end
              end
            end
            OP_SET: begin
              heading_r <= loaded_w;
              state_r   <= S_FIN;
            end
            OP_RESTART: begin
              csum_r   <= '0;
              ccount_r <= '0;
              cdone_r  <= 1'b0;
              state_r  <= S_FIN;
            end
            default: state_r <= S_FIN;
          endcase
        end
        S_MAG: begin
          mag_r       <= mag_full;
          neg_r       <= tsum[RATE_W];
          mul_start_r <= 1'b1;
          state_r     <= S_MUL;
        end
        S_MUL: begin
          if (mul_stat.done) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          r_r     <= below_db ? '0 : q_rnd;
          step_r  <= STEP_W'(RED_STEPS - 1);
          state_r <= S_RED;
        end
        S_RED: begin
          if (r_r >= turn_sh) begin
            r_r <= r_r - turn_sh;
          end
          if (step_r == '0) begin
            state_r <= S_ACC;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_ACC: begin
          heading_r <= neg_r ? dn_w[HEAD_W-1:0] : up_w[HEAD_W-1:0];
          prev_r    <= corr_r;
          state_r   <= S_FIN;
        end
        S_DIV: begin
          if (div_stat.done) begin
            bias_r   <= bias_sat;
            cdone_r  <= 1'b1;
            csum_r   <= '0;
            ccount_r <= '0;
            state_r  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r  <= '{heading: heading_r, corrected_rate: corr_r,
                             bias: bias_r, calibrated: cdone_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/sv/gyro_heading_integrator_test.sv
// Self-checking testbench for gyro_heading_integrator: directed and random requests
// against an in-bench predictor, with random sender gaps and receiver stalls.
// Depends on ghi_pkg and the gyro_heading_integrator RTL.
module gyro_heading_integrator_test;
  import ghi_pkg::*;

  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     LONG_HOLD    = 600;
  localparam int     DRAIN_SETTLE = 8;
  localparam int     END_SETTLE   = 64;
  localparam int     CALIB_MAX    = 1024;
  localparam int     PHASES       = 4;
  localparam int     PHASE_ITEMS  = 35;
  localparam longint TURN_Q24     = longint'(FULL_TURN);

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  ghi_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  ghi_out_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_RATE_SCALE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic [CFG_W-1:0]  scale_q32    = RATE_SCALE_RST;
  logic [DB_W-1:0]   deadband_q24 = DEADBAND_RST;
  logic [CLEN_W-1:0] calib_len    = CALIB_RST;
  longint            heading_q24    = 0;
  int                prev_corrected = 0;
  int                bias_est       = 0;
  longint            calib_sum      = 0;
  int                calib_count    = 0;
  bit                calib_done     = 1'b0;

  ghi_out_t    predicted_reports[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  int          hold_asks   = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          mode_left   = 0;

  gyro_heading_integrator #(.MAX_CALIB(CALIB_MAX)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_rate(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint wrap_heading(input longint h);
    longint r;
    r = h % TURN_Q24;
    if (r < 0) r += TURN_Q24;
    return r;
  endfunction

  function automatic int effective_calib_len();
    int n;
    n = calib_len;
    if (n == 0) n = 1;
    if (n > CALIB_MAX) n = CALIB_MAX;
    return n;
  endfunction

  function automatic ghi_out_t integrate_request(input ghi_in_t req);
    int              raw;
    int              corrected;
    int              rate_sum;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned q;
    longint          step;
    ghi_out_t        res;
    raw = $signed(req.rate_sample);
    corrected = 0;
    case (req.op)
      OP_RUN: begin
        corrected = clamp_rate(raw - bias_est);
        rate_sum = corrected + prev_corrected;
        mag = (rate_sum < 0) ? -rate_sum : rate_sum;
        mag = mag * req.time_step;
        prod = mag * scale_q32;
        q = prod >> FRAC_W;
        if (rate_sum < 0 && prod[FRAC_W-1:0] != 0) q = q + 1;
        step = (rate_sum < 0) ? -longint'(q) : longint'(q);
        if (q < deadband_q24) step = 0;
        heading_q24 = wrap_heading(heading_q24 + step);
        prev_corrected = corrected;
      end
      OP_CALIB: begin
        if (!calib_done) begin
          calib_sum += raw;
          calib_count++;
          if (calib_count >= effective_calib_len()) begin
            bias_est = clamp_rate(int'(calib_sum / calib_count));
            calib_done = 1'b1;
            calib_sum = 0;
            calib_count = 0;
          end
        end
      end
      OP_SET: heading_q24 = wrap_heading(longint'(req.new_heading));
      OP_RESTART: begin
        calib_sum = 0;
        calib_count = 0;
        calib_done = 1'b0;
      end
    endcase
    res.heading        = heading_q24[HEAD_W-1:0];
    res.corrected_rate = corrected[RATE_W-1:0];
    res.bias           = bias_est[RATE_W-1:0];
    res.calibrated     = calib_done;
    return res;
  endfunction

  function automatic ghi_in_t random_request();
    ghi_in_t     r;
    logic [63:0] w;
    w = {$urandom, $urandom};
    r.op          = ghi_op_t'($urandom_range(0, 3));
    r.rate_sample = RATE_W'($urandom);
    r.time_step   = DT_W'($urandom);
    r.new_heading = w[HEAD_W-1:0];
    return r;
  endfunction

  function automatic ghi_in_t request_of(input ghi_op_t op, input int rate, input int dt,
                                         input longint hdg);
    ghi_in_t r;
    r.op          = op;
    r.rate_sample = rate[RATE_W-1:0];
    r.time_step   = dt[DT_W-1:0];
    r.new_heading = hdg[HEAD_W-1:0];
    return r;
  endfunction

  task automatic send_request(input ghi_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_reports.push_back(integrate_request(req));
  endtask

  task automatic offer_request(input ghi_in_t req);
    int gap;
    send_request(req);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) begin
        in_data <= random_request();
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 20);
    end
  endtask

  task automatic wait_for_results(input int settle);
    in_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] scale, input logic [DB_W-1:0] db,
                                input logic [CLEN_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RATE_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_index <= REG_DEADBAND;
    cfg_wdata <= CFG_W'(db);
    @(posedge clk);
    cfg_index <= REG_CALIB_SAMPLES;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    scale_q32    = scale;
    deadband_q24 = db;
    calib_len    = len;
  endtask

  task automatic test_reset_defaults();
    offer_request(request_of(OP_RUN, 1000, 1000, 0));
    offer_request(request_of(OP_RUN, 1000, 1000, 0));
    offer_request(request_of(OP_RUN, -3000, 2000, 0));
    offer_request(request_of(OP_CALIB, 100, 0, 0));
    offer_request(request_of(OP_CALIB, -100, 0, 0));
    offer_request(request_of(OP_SET, 0, 0, longint'(90) << 24));
    offer_request(request_of(OP_RESTART, 0, 0, 0));
  endtask

  task automatic test_saturation_extremes();
    wait_for_results(DRAIN_SETTLE);
    apply_settings(32'hFFFF_FFFF, '0, 11'd1);
    offer_request(request_of(OP_CALIB, 32767, 0, 0));
    offer_request(request_of(OP_CALIB, -5, 0, 0));
    offer_request(request_of(OP_RUN, -32768, 65535, 0));
    offer_request(request_of(OP_RUN, -32768, 65535, 0));
    offer_request(request_of(OP_RESTART, 0, 0, 0));
    offer_request(request_of(OP_CALIB, -32768, 0, 0));
    offer_request(request_of(OP_RUN, 32767, 65535, 0));
    offer_request(request_of(OP_RUN, 32767, 65535, 0));
    offer_request(request_of(OP_RUN, 0, 0, 0));
    offer_request(request_of(OP_SET, 0, 0, 64'h1_FFFF_FFFF));
    offer_request(request_of(OP_SET, 0, 0, TURN_Q24 - 1));
    offer_request(request_of(OP_SET, 0, 0, TURN_Q24));
    offer_request(request_of(OP_SET, 0, 0, 0));
    wait_for_results(DRAIN_SETTLE);
    apply_settings('0, 25'h1FF_FFFF, 11'd2047);
    offer_request(request_of(OP_RUN, 32767, 65535, 0));
    wait_for_results(DRAIN_SETTLE);
    apply_settings(RATE_SCALE_RST, 25'd16777216, 11'd1024);
    offer_request(request_of(OP_RUN, -32768, 65535, 0));
  endtask

  task automatic test_calibration_length();
    wait_for_results(DRAIN_SETTLE);
    apply_settings(RATE_SCALE_RST, DEADBAND_RST, 11'd40);
    offer_request(request_of(OP_RESTART, 0, 0, 0));
    offer_request(request_of(OP_CALIB, -7, 0, 0));
    offer_request(request_of(OP_CALIB, 3, 0, 0));
    offer_request(request_of(OP_CALIB, 11, 0, 0));
    offer_request(request_of(OP_CALIB, -20, 0, 0));
    wait_for_results(DRAIN_SETTLE);
    apply_settings(RATE_SCALE_RST, DEADBAND_RST, 11'd3);
    offer_request(request_of(OP_CALIB, -9, 0, 0));
    offer_request(request_of(OP_RUN, 50, 5000, 0));
    wait_for_results(DRAIN_SETTLE);
    apply_settings(RATE_SCALE_RST, DEADBAND_RST, '0);
    offer_request(request_of(OP_RESTART, 0, 0, 0));
    offer_request(request_of(OP_CALIB, 1234, 0, 0));
    offer_request(request_of(OP_CALIB, 77, 0, 0));
  endtask

  task automatic test_output_backpressure();
    ghi_in_t req;
    wait_for_results(DRAIN_SETTLE);
    hold_asks++;
    repeat (24) begin
      req = random_request();
      req.op = ($urandom_range(0, 3) == 0) ? OP_CALIB : OP_RUN;
      send_request(req);
    end
    wait_for_results(DRAIN_SETTLE);
  endtask

  task automatic test_long_calibration();
    ghi_in_t req;
    int      center;
    wait_for_results(DRAIN_SETTLE);
    apply_settings($urandom, DEADBAND_RST, 11'd2047);
    center = $urandom_range(0, 20000) - 10000;
    offer_request(request_of(OP_RESTART, 0, 0, 0));
    repeat (CALIB_MAX + 1) begin
      req = random_request();
      req.op = OP_CALIB;
      if ($urandom_range(0, 9) != 0)
        req.rate_sample = RATE_W'(clamp_rate(center + $urandom_range(0, 4000) - 2000));
      offer_request(req);
    end
    repeat (5) begin
      req = random_request();
      req.op = OP_RUN;
      offer_request(req);
    end
  endtask

  task automatic test_random_traffic();
    ghi_in_t           req;
    logic [CFG_W-1:0]  scale;
    logic [DB_W-1:0]   db;
    logic [CLEN_W-1:0] len;
    int                sent;
    int                center;
    int                pick;
    int                need;
    int                count;
    for (int phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 5))
        0:       scale = '0;
        1:       scale = 32'hFFFF_FFFF;
        2:       scale = RATE_SCALE_RST;
        default: scale = $urandom;
      endcase
      case ($urandom_range(0, 6))
        0:       db = '0;
        1:       db = 25'd16777216;
        2:       db = 25'h1FF_FFFF;
        default: db = DB_W'($urandom_range(0, 1 << 20));
      endcase
      case ($urandom_range(0, 7))
        0:       len = '0;
        1:       len = 11'd2047;
        2:       len = 11'd1024;
        default: len = CLEN_W'($urandom_range(1, 12));
      endcase
      wait_for_results(DRAIN_SETTLE);
      apply_settings(scale, db, len);
      center = $urandom_range(0, 8000) - 4000;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          offer_request(random_request());
          sent++;
        end else if (pick < 20) begin
          need = effective_calib_len();
          if (need > 40) need = $urandom_range(1, 40);
          req = random_request();
          req.op = OP_RESTART;
          offer_request(req);
          sent++;
          repeat (need + $urandom_range(0, 2)) begin
            req = random_request();
            req.op = OP_CALIB;
            req.rate_sample = RATE_W'(clamp_rate(center + $urandom_range(0, 600) - 300));
            offer_request(req);
            sent++;
          end
        end else if (pick < 25) begin
          req = random_request();
          req.op = OP_SET;
          offer_request(req);
          sent++;
        end else begin
          count = $urandom_range(1, 30);
          repeat (count) begin
            req = random_request();
            req.op = OP_RUN;
            if ($urandom_range(0, 9) < 7)
              req.rate_sample = RATE_W'(clamp_rate(center + $urandom_range(0, 3000) - 1500));
            case ($urandom_range(0, 9))
              0:       req.time_step = '0;
              1:       req.time_step = '1;
              default: ;
            endcase
            offer_request(req);
            sent++;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= ((mode_left % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin : check_reports
    ghi_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_reports.size() == 0) begin
        $error("result with nothing pending: heading %0d", out_data.heading);
        error_count++;
      end else begin
        want = predicted_reports.pop_front();
        if (out_data.heading !== want.heading) begin
          $error("heading: expected %0d, got %0d", want.heading, out_data.heading);
          error_count++;
        end
        if (out_data.corrected_rate !== want.corrected_rate) begin
          $error("corrected_rate: expected %0d, got %0d",
                 want.corrected_rate, out_data.corrected_rate);
          error_count++;
        end
        if (out_data.bias !== want.bias) begin
          $error("bias: expected %0d, got %0d", want.bias, out_data.bias);
          error_count++;
        end
        if (out_data.calibrated !== want.calibrated) begin
          $error("calibrated: expected %0d, got %0d", want.calibrated, out_data.calibrated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gyro_heading_integrator_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_saturation_extremes();
    test_calibration_length();
    test_output_backpressure();
    test_long_calibration();
    test_random_traffic();
    wait_for_results(END_SETTLE);
    if (error_count == 0) begin
      $display("gyro_heading_integrator_test: clean");
    end else begin
      $display("gyro_heading_integrator_test: errors");
    end
    $finish;
  end

endmodule
